/* design/stb_pkg.sv */
// shared types, constants and font tables for the scrolling text banner
package stb_pkg;

   localparam int MAX_MESSAGE = 64;
   localparam int ADDR_W      = $clog2(MAX_MESSAGE);
   localparam int LEN_W       = 7;
   localparam int CODE_W      = 7;
   localparam int INDEX_W     = 6;
   localparam int ROW_W       = 30;
   localparam int ROWS        = 6;
   localparam int GLYPH_COL   = 25;
   localparam int GLYPH_W     = 5;
   localparam int CD_W        = 3;
   localparam int FIRST_GLYPH = 48;
   localparam int GLYPH_COUNT = 43;

   // transaction command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // per-cycle control from the sequencer to the column cells
   typedef struct packed {
      logic                     shift;
      logic [GLYPH_W*ROWS-1:0]  glyph;
   } band_ctl_type;

   // 5x6 glyph for '0' to 'Z', row r in bits 5r..5r+4, blank otherwise
   function automatic logic [GLYPH_W*ROWS-1:0] font_glyph(input logic [CODE_W-1:0] code);
      logic [GLYPH_W*ROWS-1:0] g;
      g = '0;
      case (code)
         7'h30: g = 30'd6595878;
         7'h31: g = 30'd7407683;
         7'h32: g = 30'd15767815;
         7'h33: g = 30'd7608583;
         7'h34: g = 30'd4691109;
         7'h35: g = 30'd7609391;
         7'h36: g = 30'd6593574;
         7'h37: g = 30'd2167055;
         7'h38: g = 30'd6592806;
         7'h39: g = 30'd6568230;
         7'h3A: g = 30'd32800;
         7'h3B: g = 30'd1114176;
         7'h3C: g = 30'd4260932;
         7'h3D: g = 30'd229600;
         7'h3E: g = 30'd1118273;
         7'h3F: g = 30'd2103559;
         7'h40: g = 30'd14726830;
         7'h41: g = 30'd9747750;
         7'h42: g = 30'd7642407;
         7'h43: g = 30'd6587686;
         7'h44: g = 30'd7644455;
         7'h45: g = 30'd7380007;
         7'h46: g = 30'd1088551;
         7'h47: g = 30'd6599726;
         7'h48: g = 30'd9747753;
         7'h49: g = 30'd1082401;
         7'h4A: g = 30'd6594824;
         7'h4B: g = 30'd9604265;
         7'h4C: g = 30'd7373857;
         7'h4D: g = 30'd18405233;
         7'h4E: g = 30'd18667121;
         7'h4F: g = 30'd6595878;
         7'h50: g = 30'd1088807;
         7'h51: g = 30'd275031334;
         7'h52: g = 30'd9608487;
         7'h53: g = 30'd7608366;
         7'h54: g = 30'd2164807;
         7'h55: g = 30'd6595881;
         7'h56: g = 30'd4532785;
         7'h57: g = 30'd11196081;
         7'h58: g = 30'd18157905;
         7'h59: g = 30'd4329809;
         7'h5A: g = 30'd7374983;
         default: g = '0;
      endcase
      return g;
   endfunction

   // proportional character width in columns
   function automatic logic [CD_W-1:0] glyph_width(input logic [CODE_W-1:0] code);
      logic [CD_W-1:0] w;
      case (code) inside
         7'h3A, 7'h49: w = 3'd1;
         7'h3B: w = 3'd2;
         7'h31, 7'h3C, 7'h3D, 7'h3E, 7'h45, 7'h46, 7'h4C, 7'h54, 7'h5A: w = 3'd3;
         7'h40, 7'h4D, 7'h4E, 7'h56, 7'h57, 7'h58, 7'h59: w = 3'd5;
         default: w = 3'd4;
      endcase
      return w;
   endfunction

endpackage

/* design/stb_ifs.sv */
// request and response channel interfaces of the banner
interface stb_req_if;
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [stb_pkg::INDEX_W-1:0]     char_index;
   logic [stb_pkg::CODE_W-1:0]      char_code;

   modport source (output valid, output command, output char_index, output char_code,
                   input ready);
   modport sink   (input valid, input command, input char_index, input char_code,
                   output ready);
endinterface

interface stb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [stb_pkg::ROW_W-1:0]       row_0;
   logic [stb_pkg::ROW_W-1:0]       row_1;
   logic [stb_pkg::ROW_W-1:0]       row_2;
   logic [stb_pkg::ROW_W-1:0]       row_3;
   logic [stb_pkg::ROW_W-1:0]       row_4;
   logic [stb_pkg::ROW_W-1:0]       row_5;
   logic                            wrapped;

   modport source (output valid, output row_0, output row_1, output row_2, output row_3,
                   output row_4, output row_5, output wrapped, input ready);
   modport sink   (input valid, input row_0, input row_1, input row_2, input row_3,
                   input row_4, input row_5, input wrapped, output ready);
endinterface

/* design/stb_cell.sv */
// one band column cell: six pixels that move one column left per tick
module stb_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift,
   input  logic [stb_pkg::ROWS-1:0]    right_col,
   input  logic [stb_pkg::ROWS-1:0]    inject,
   output logic [stb_pkg::ROWS-1:0]    col
);

   logic [stb_pkg::ROWS-1:0] col_ff;
   logic [stb_pkg::ROWS-1:0] col_in;

   // take the neighbor's pixels, merged with any freshly drawn glyph column
   always_comb begin
      col_in = col_ff;
      if (shift) begin
         col_in = right_col | inject;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   assign col = col_ff;

endmodule

/* design/stb_seq.sv */
// message store, position, column countdown and glyph selection
module stb_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             command,
   input  logic [stb_pkg::INDEX_W-1:0]      char_index,
   input  logic [stb_pkg::CODE_W-1:0]       char_code,
   input  logic                             csr_wr_en,
   input  logic [stb_pkg::LEN_W-1:0]        csr_wr_data,
   output stb_pkg::band_ctl_type            band_ctl,
   output logic                             wrapped
);

   logic [stb_pkg::CODE_W-1:0]  mem [stb_pkg::MAX_MESSAGE];
   logic [stb_pkg::CODE_W-1:0]  rd_ff;
   logic [stb_pkg::ADDR_W-1:0]  pos_ff;
   logic [stb_pkg::ADDR_W-1:0]  pos_in;
   logic [stb_pkg::CD_W-1:0]    cd_ff;
   logic [stb_pkg::CD_W-1:0]    cd_in;
   logic [stb_pkg::LEN_W-1:0]   len_ff;
   logic [stb_pkg::LEN_W-1:0]   len_eff;
   logic                        wrap_ff;
   logic                        wrap_in;
   logic                        load;
   logic                        tick;
   logic                        draw;
   logic                        wr_en;
   logic [stb_pkg::ADDR_W-1:0]  wr_addr;
   logic [stb_pkg::ADDR_W:0]    pos_adv;

   assign load    = accept && (command == stb_pkg::CMD_LOAD);
   assign tick    = accept && (command == stb_pkg::CMD_TICK);
   assign draw    = tick && (cd_ff == '0);
   assign wr_en   = load && (32'(char_index) < stb_pkg::MAX_MESSAGE);
   assign wr_addr = stb_pkg::ADDR_W'(char_index);

   // effective message length, clamped to 1..MAX_MESSAGE
   always_comb begin
      len_eff = len_ff;
      if (len_ff == '0) begin
         len_eff = stb_pkg::LEN_W'(1);
      end else if (32'(len_ff) > stb_pkg::MAX_MESSAGE) begin
         len_eff = stb_pkg::LEN_W'(stb_pkg::MAX_MESSAGE);
      end
   end

   // position, countdown and wrap update
   always_comb begin
      pos_adv = {1'b0, pos_ff} + (stb_pkg::ADDR_W+1)'(draw);
      pos_in  = pos_ff;
      cd_in   = cd_ff;
      wrap_in = wrap_ff;
      if (load) begin
         pos_in  = '0;
         cd_in   = '0;
         wrap_in = 1'b0;
      end else if (tick) begin
         cd_in = draw ? stb_pkg::glyph_width(rd_ff) : cd_ff - 1'b1;
         if (32'(pos_adv) >= 32'(len_eff)) begin
            pos_in  = '0;
            wrap_in = 1'b1;
         end else begin
            pos_in  = stb_pkg::ADDR_W'(pos_adv);
            wrap_in = 1'b0;
         end
      end
   end

   // glyph for the cells, blank when no character is drawn
   always_comb begin
      band_ctl.shift = tick;
      band_ctl.glyph = draw ? stb_pkg::font_glyph(rd_ff) : '0;
   end

   // message memory, read ahead at the next position with write bypass
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= char_code;
      end
      if (wr_en && (wr_addr == pos_in)) begin
         rd_ff <= char_code;
      end else begin
         rd_ff <= mem[pos_in];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         cd_ff   <= '0;
         wrap_ff <= 1'b0;
         len_ff  <= stb_pkg::LEN_W'(1);
      end else begin
         pos_ff  <= pos_in;
         cd_ff   <= cd_in;
         wrap_ff <= wrap_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
      end
   end

   assign wrapped = wrap_ff;

   // a drawn character always leaves a nonzero countdown
   assert property (@(posedge clock) disable iff (reset) draw |=> cd_ff != '0)
      else $error("countdown zero right after a drawn character");

   // a load restarts the message
   assert property (@(posedge clock) disable iff (reset)
      load |=> (pos_ff == '0) && (cd_ff == '0) && !wrap_ff)
      else $error("load did not restart the message");

   // a wrap always returns the position to the start
   assert property (@(posedge clock) disable iff (reset)
      tick |=> !wrap_ff || (pos_ff == '0))
      else $error("wrapped reported with nonzero position");

endmodule

/* design/scrolling_text_banner_unit.sv */
// top level of the scrolling text banner: sequencer, column cells and response register
//
//   channel   direction  handshake         payload
//   req_bus   in         valid/ready       command, char_index, char_code
//   rsp_bus   out        valid/ready       row_0..row_5, wrapped
//   csr_*     in         csr_wr_en only    message_length
//
// one transaction per cycle while no response is stalled; each result shows in the cycle after its request is accepted
// the band's 30 column cells and the response valid flag form the output register
// message memory is read ahead into a register at the next position, bypassing same-cycle loads
// reset is synchronous; it clears the band, position, countdown and sets length to 1
// a stalled response holds req_bus.ready low until it is taken
module scrolling_text_banner_unit (
   input  logic                        clock,
   input  logic                        reset,
   stb_req_if.sink                     req_bus,
   stb_rsp_if.source                   rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [stb_pkg::LEN_W-1:0]   csr_wr_data
);

   localparam int COLS = stb_pkg::ROW_W;

   stb_pkg::band_ctl_type        band_ctl;
   logic [stb_pkg::ROWS-1:0]     cols [COLS];
   logic                         accept;
   logic                         valid_ff;
   logic                         valid_in;
   logic                         wrapped;

   // handshake
   assign req_bus.ready = !valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign valid_in      = accept || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   stb_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_bus.command),
      .char_index  (req_bus.char_index),
      .char_code   (req_bus.char_code),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .band_ctl    (band_ctl),
      .wrapped     (wrapped)
   );

   // row of column cells, glyph columns enter just left of the drawing area
   for (genvar k = 0; k < COLS; k++) begin : g_col
      logic [stb_pkg::ROWS-1:0] right_col;
      logic [stb_pkg::ROWS-1:0] inject;

      if (k == COLS-1) begin : g_edge
         assign right_col = '0;
      end else begin : g_mid
         assign right_col = cols[k+1];
      end

      if ((k + 1 >= stb_pkg::GLYPH_COL) && (k + 1 < stb_pkg::GLYPH_COL + stb_pkg::GLYPH_W))
      begin : g_glyph
         for (genvar r = 0; r < stb_pkg::ROWS; r++) begin : g_row
            assign inject[r] =
               band_ctl.glyph[stb_pkg::GLYPH_W*r + (k + 1 - stb_pkg::GLYPH_COL)];
         end
      end else begin : g_plain
         assign inject = '0;
      end

      stb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (band_ctl.shift),
         .right_col (right_col),
         .inject    (inject),
         .col       (cols[k])
      );
   end

   // gather band columns into response rows
   for (genvar k = 0; k < COLS; k++) begin : g_out
      assign rsp_bus.row_0[k] = cols[k][0];
      assign rsp_bus.row_1[k] = cols[k][1];
      assign rsp_bus.row_2[k] = cols[k][2];
      assign rsp_bus.row_3[k] = cols[k][3];
      assign rsp_bus.row_4[k] = cols[k][4];
      assign rsp_bus.row_5[k] = cols[k][5];
   end

   assign rsp_bus.valid   = valid_ff;
   assign rsp_bus.wrapped = wrapped;

   // every accepted request yields a response in the next cycle
   assert property (@(posedge clock) disable iff (reset) accept |=> rsp_bus.valid)
      else $error("accepted transaction produced no response");

   // the band only moves when a tick is accepted
   assert property (@(posedge clock) disable iff (reset)
      !band_ctl.shift |=> $stable(rsp_bus.row_0) && $stable(rsp_bus.row_5))
      else $error("band changed without a tick");

   // a tick with nothing new drawn moves the top row left by one column
   assert property (@(posedge clock) disable iff (reset)
      band_ctl.shift && (band_ctl.glyph == '0) |=>
         rsp_bus.row_0 == ($past(rsp_bus.row_0) >> 1))
      else $error("band did not shift on tick");

endmodule

/* bench/tb_top.sv */
// self-checking testbench for the scrolling text banner unit
module tb_top;

   // one result transaction as seen on the response channel
   typedef struct packed {
      logic [stb_pkg::ROWS-1:0][stb_pkg::ROW_W-1:0] rows;
      logic                                         wrapped;
   } banner_frame_type;

   // running copy of the band, message and scroll counters, plus the frames still owed
   class band_tracker_type;
      logic [stb_pkg::ROW_W-1:0]  rows [stb_pkg::ROWS];
      logic [stb_pkg::CODE_W-1:0] store [stb_pkg::MAX_MESSAGE];
      bit                         written [stb_pkg::MAX_MESSAGE];
      int unsigned                position;
      logic [stb_pkg::CD_W-1:0]   countdown;
      logic [stb_pkg::LEN_W-1:0]  msg_length;
      banner_frame_type           expected_frames [$];
      int unsigned                faults;

      function new();
         foreach (rows[r]) rows[r] = '0;
         foreach (store[i]) store[i] = '0;
         foreach (written[i]) written[i] = 1'b0;
         position   = 0;
         countdown  = '0;
         msg_length = 7'd1;
         faults     = 0;
      endfunction

      function void set_length(input logic [stb_pkg::LEN_W-1:0] setting);
         msg_length = setting;
      endfunction

      function int unsigned pending();
         return expected_frames.size();
      endfunction

      // a tick now would fetch a message entry that nobody loaded yet
      function bit reads_unwritten();
         return countdown == 0 && position < stb_pkg::MAX_MESSAGE && !written[position];
      endfunction

      // 5x6 pixel pattern per character, row r in bits 5r..5r+4
      function logic [stb_pkg::ROW_W-1:0] glyph_shape(input logic [stb_pkg::CODE_W-1:0] code);
         case (code)
            7'h30: return 30'd6595878;    // 0
            7'h31: return 30'd7407683;
            7'h32: return 30'd15767815;
            7'h33: return 30'd7608583;
            7'h34: return 30'd4691109;
            7'h35: return 30'd7609391;
            7'h36: return 30'd6593574;
            7'h37: return 30'd2167055;
            7'h38: return 30'd6592806;
            7'h39: return 30'd6568230;
            7'h3A: return 30'd32800;      // colon
            7'h3B: return 30'd1114176;
            7'h3C: return 30'd4260932;
            7'h3D: return 30'd229600;
            7'h3E: return 30'd1118273;
            7'h3F: return 30'd2103559;
            7'h40: return 30'd14726830;   // at sign
            7'h41: return 30'd9747750;    // A
            7'h42: return 30'd7642407;
            7'h43: return 30'd6587686;
            7'h44: return 30'd7644455;
            7'h45: return 30'd7380007;
            7'h46: return 30'd1088551;
            7'h47: return 30'd6599726;
            7'h48: return 30'd9747753;
            7'h49: return 30'd1082401;
            7'h4A: return 30'd6594824;
            7'h4B: return 30'd9604265;
            7'h4C: return 30'd7373857;
            7'h4D: return 30'd18405233;
            7'h4E: return 30'd18667121;
            7'h4F: return 30'd6595878;
            7'h50: return 30'd1088807;
            7'h51: return 30'd275031334;  // Q, reaches the bottom glyph row
            7'h52: return 30'd9608487;
            7'h53: return 30'd7608366;
            7'h54: return 30'd2164807;
            7'h55: return 30'd6595881;
            7'h56: return 30'd4532785;
            7'h57: return 30'd11196081;
            7'h58: return 30'd18157905;
            7'h59: return 30'd4329809;
            7'h5A: return 30'd7374983;    // Z
            default: return '0;
         endcase
      endfunction

      // proportional advance in columns, blanks included
      function logic [stb_pkg::CD_W-1:0] glyph_cols(input logic [stb_pkg::CODE_W-1:0] code);
         case (code)
            7'h3A, 7'h49: return 3'd1;
            7'h3B: return 3'd2;
            7'h31, 7'h3C, 7'h3D, 7'h3E, 7'h45, 7'h46, 7'h4C, 7'h54, 7'h5A: return 3'd3;
            7'h40, 7'h4D, 7'h4E, 7'h56, 7'h57, 7'h58, 7'h59: return 3'd5;
            default: return 3'd4;
         endcase
      endfunction

      // apply one accepted request and queue the frame it must produce
      function void note_request(input logic cmd, input logic [stb_pkg::INDEX_W-1:0] idx,
                                 input logic [stb_pkg::CODE_W-1:0] code);
         banner_frame_type           frame;
         int unsigned                span;
         logic [stb_pkg::CODE_W-1:0] ch;
         logic [stb_pkg::ROW_W-1:0]  shape;
         frame.wrapped = 1'b0;
         if (cmd == stb_pkg::CMD_LOAD) begin
            store[idx]   = code;
            written[idx] = 1'b1;
            position     = 0;
            countdown    = '0;
         end else begin
            span = (msg_length == 0) ? 1 :
                   (msg_length > stb_pkg::MAX_MESSAGE) ? stb_pkg::MAX_MESSAGE : msg_length;
            // draw the next character at the right edge
            if (countdown == 0) begin
               ch = (position < stb_pkg::MAX_MESSAGE) ? store[position] : '0;
               position++;
               shape = glyph_shape(ch);
               for (int r = 0; r < stb_pkg::ROWS; r++)
                  rows[r][stb_pkg::GLYPH_COL +: stb_pkg::GLYPH_W] =
                     rows[r][stb_pkg::GLYPH_COL +: stb_pkg::GLYPH_W]
                     | shape[stb_pkg::GLYPH_W*r +: stb_pkg::GLYPH_W];
               countdown = glyph_cols(ch) + 3'd1;
            end
            countdown = countdown - 3'd1;
            for (int r = 0; r < stb_pkg::ROWS; r++)
               rows[r] = rows[r] >> 1;
            // end of message, including a length lowered under the position
            if (position >= span) begin
               position      = 0;
               frame.wrapped = 1'b1;
            end
         end
         for (int r = 0; r < stb_pkg::ROWS; r++)
            frame.rows[r] = rows[r];
         expected_frames.push_back(frame);
      endfunction

      function void report(input string field, input logic [31:0] want,
                           input logic [31:0] got);
         faults++;
         if (faults <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
      endfunction

      // compare one response transaction with the oldest owed frame
      function void check_frame(input banner_frame_type got);
         banner_frame_type want;
         if (expected_frames.size() == 0) begin
            report("row_0 of transaction with nothing owed", '0, got.rows[0]);
            return;
         end
         want = expected_frames.pop_front();
         for (int r = 0; r < stb_pkg::ROWS; r++)
            if (got.rows[r] !== want.rows[r])
               report($sformatf("row_%0d", r), want.rows[r], got.rows[r]);
         if (got.wrapped !== want.wrapped)
            report("wrapped", want.wrapped, got.wrapped);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_wr_en;
   logic [stb_pkg::LEN_W-1:0] csr_wr_data;

   stb_req_if req_bus ();
   stb_rsp_if rsp_bus ();

   band_tracker_type band = new();
   bit               calm = 1'b0;
   int unsigned      requests_sent = 0;
   int unsigned      frames_seen = 0;

   scrolling_text_banner_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock generation
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop if the run hangs
   initial begin
      #8000000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int unsigned draw_pause();
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   // printable glyphs most of the time, spaces and arbitrary codes now and then
   function automatic logic [stb_pkg::CODE_W-1:0] message_code();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 8)
         return stb_pkg::CODE_W'($urandom_range(48, 90));
      if (pick == 8)
         return 7'h20;
      return stb_pkg::CODE_W'($urandom_range(0, 127));
   endfunction

   // offer one request transaction and wait until it is taken
   task automatic send_item(input logic cmd, input logic [stb_pkg::INDEX_W-1:0] idx,
                            input logic [stb_pkg::CODE_W-1:0] code);
      int unsigned gap;
      gap = draw_pause();
      if ($urandom_range(0, 39) == 0)
         calm = !calm;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.char_index <= idx;
      req_bus.char_code  <= code;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      band.note_request(cmd, idx, code);
      requests_sent++;
   endtask

   // a scroll tick, unless it would fetch an unloaded entry: then load that entry first
   task automatic tick_item();
      if (band.reads_unwritten())
         send_item(stb_pkg::CMD_LOAD, stb_pkg::INDEX_W'(band.position), message_code());
      else
         send_item(stb_pkg::CMD_TICK, stb_pkg::INDEX_W'($urandom_range(0, 63)),
                   stb_pkg::CODE_W'($urandom_range(0, 127)));
   endtask

   task automatic load_message(input int unsigned count);
      for (int i = 0; i < count; i++)
         send_item(stb_pkg::CMD_LOAD, stb_pkg::INDEX_W'(i), message_code());
   endtask

   // drain the block, then write the length register
   task automatic write_length(input logic [stb_pkg::LEN_W-1:0] setting);
      req_bus.valid <= 1'b0;
      while (band.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= setting;
      @(posedge clock);
      band.set_length(setting);
      csr_wr_en <= 1'b0;
   endtask

   // one length setting: mixed ticks, message and stray loads, then an optional full lap
   task automatic run_phase(input logic [stb_pkg::LEN_W-1:0] setting,
                            input int unsigned budget, input bit full_lap);
      int unsigned first;
      int unsigned span;
      int unsigned pick;
      write_length(setting);
      span  = (setting == 0) ? 1 :
              (setting > stb_pkg::MAX_MESSAGE) ? stb_pkg::MAX_MESSAGE : setting;
      first = requests_sent;
      while (requests_sent - first < budget) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)
            repeat ($urandom_range(1, 30)) tick_item();
         else if (pick < 8)
            load_message($urandom_range(1, span));
         else
            send_item(stb_pkg::CMD_LOAD, stb_pkg::INDEX_W'($urandom_range(0, 63)),
                      stb_pkg::CODE_W'($urandom_range(0, 127)));
      end
      // whole message then enough ticks to scroll past its end
      if (full_lap) begin
         load_message(span);
         repeat (390) tick_item();
      end
   endtask

   // response side: random back-pressure, one long hold-off under load
   initial begin
      int unsigned      hold;
      bit               long_done;
      banner_frame_type got;
      rsp_bus.ready <= 1'b0;
      long_done = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      hold = draw_pause();
      forever begin
         if (hold != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.rows[0] = rsp_bus.row_0;
         got.rows[1] = rsp_bus.row_1;
         got.rows[2] = rsp_bus.row_2;
         got.rows[3] = rsp_bus.row_3;
         got.rows[4] = rsp_bus.row_4;
         got.rows[5] = rsp_bus.row_5;
         got.wrapped = rsp_bus.wrapped;
         band.check_frame(got);
         frames_seen++;
         hold = draw_pause();
         if (!long_done && frames_seen >= 300 && req_bus.valid === 1'b1) begin
            hold      = 60;
            long_done = 1'b1;
         end
      end
   end

   // reset, directed cases, random phases, drain and verdict
   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.command    <= stb_pkg::CMD_LOAD;
      req_bus.char_index <= '0;
      req_bus.char_code  <= '0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: length one, so every drawn character wraps
      send_item(stb_pkg::CMD_LOAD, 6'd0, 7'h51);           // Q, tallest glyph
      repeat (6) tick_item();
      send_item(stb_pkg::CMD_LOAD, 6'd63, 7'h7F);          // top index, top code
      send_item(stb_pkg::CMD_LOAD, 6'd0, 7'h00);           // code zero draws blank
      repeat (2) tick_item();
      send_item(stb_pkg::CMD_LOAD, 6'd0, 7'h20);           // space
      tick_item();
      send_item(stb_pkg::CMD_LOAD, 6'd0, 7'h3A);           // narrowest glyph
      repeat (3) tick_item();
      send_item(stb_pkg::CMD_LOAD, 6'd0, 7'h49);
      repeat (2) tick_item();
      send_item(stb_pkg::CMD_LOAD, 6'd0, 7'h40);           // widest glyph
      tick_item();
      send_item(stb_pkg::CMD_LOAD, 6'd0, 7'h5A);           // last glyph in the font
      tick_item();

      // random phases across the length range, out-of-range settings included
      run_phase(7'd64, 40, 1'b0);
      run_phase(7'd3, 30, 1'b0);
      run_phase(7'd0, 25, 1'b0);
      run_phase(7'd127, 15, 1'b1);
      run_phase(stb_pkg::LEN_W'($urandom_range(2, 63)), 40, 1'b0);
      run_phase(7'd1, 25, 1'b0);
      run_phase(stb_pkg::LEN_W'($urandom_range(65, 126)), 25, 1'b0);

      req_bus.valid <= 1'b0;
      while (band.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (band.faults == 0 && band.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
